// File: design/tcpu_pkg.sv
// ----------------------------------------------------------------------------
// tcpu_pkg: shared types and codes for the tiny 16-bit core
// Opcodes, event codes, sequencer states and the ALU request/response records.
// ----------------------------------------------------------------------------
package tcpu_pkg;
	localparam int WORD_BITS = 16;
	localparam int REG_COUNT = 8;
	localparam int REG_BITS  = $clog2(REG_COUNT);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [REG_BITS-1:0]  ridx_t;

	localparam logic [1:0] ACT_EXEC = 2'd0;
	localparam logic [1:0] ACT_LOAD = 2'd1;
	localparam logic [1:0] ACT_IRQ  = 2'd2;

	localparam logic [1:0] ACC_NONE  = 2'd0;
	localparam logic [1:0] ACC_LOAD  = 2'd1;
	localparam logic [1:0] ACC_STORE = 2'd2;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_SYSCALL = 3'd1;
	localparam logic [2:0] EV_IRQ     = 3'd2;
	localparam logic [2:0] EV_REFUSED = 3'd3;
	localparam logic [2:0] EV_ILLEGAL = 3'd4;
	localparam logic [2:0] EV_BUSY    = 3'd5;

	localparam logic [5:0] OP_ADD   = 6'd0;
	localparam logic [5:0] OP_SUB   = 6'd1;
	localparam logic [5:0] OP_MUL   = 6'd2;
	localparam logic [5:0] OP_DIV   = 6'd3;
	localparam logic [5:0] OP_EQ    = 6'd4;
	localparam logic [5:0] OP_NE    = 6'd5;
	localparam logic [5:0] OP_LOAD  = 6'd15;
	localparam logic [5:0] OP_STORE = 6'd16;
	localparam logic [5:0] OP_SYS   = 6'd63;

	localparam logic [1:0] IOP_JMP  = 2'd0;
	localparam logic [1:0] IOP_JEQ1 = 2'd1;
	localparam logic [1:0] IOP_MOVI = 2'd3;

	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_SUB = 3'd1,
		ALU_MUL = 3'd2,
		ALU_DIV = 3'd3,
		ALU_EQ  = 3'd4,
		ALU_NE  = 3'd5
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		word_t   a;
		word_t   b;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		word_t result;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_ALU  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;
endpackage

// File: design/tcpu_alu.sv
// ----------------------------------------------------------------------------
// tcpu_alu: shared arithmetic unit
// Add, sub, compare and multiply results are registered; divide restores one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcpu_alu import tcpu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);
	localparam int CNT_BITS = $clog2(WORD_BITS + 1);

	logic                busy_q;
	logic [CNT_BITS-1:0] cnt_q;
	word_t               quo_q;
	word_t               rem_q;
	word_t               div_q;
	logic [WORD_BITS:0]  trial;
	logic [31:0]         prod;

	assign trial = {rem_q, quo_q[WORD_BITS-1]} - {1'b0, div_q};
	assign prod  = 32'(req.a) * 32'(req.b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rsp    <= '0;
		end else begin
			if (busy_q) begin
				if (trial[WORD_BITS]) begin
					rem_q <= {rem_q[WORD_BITS-2:0], quo_q[WORD_BITS-1]};
					quo_q <= {quo_q[WORD_BITS-2:0], 1'b0};
				end else begin
					rem_q <= trial[WORD_BITS-1:0];
					quo_q <= {quo_q[WORD_BITS-2:0], 1'b1};
				end
				cnt_q    <= cnt_q - 1'b1;
				rsp.done <= (cnt_q == CNT_BITS'(1));
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q     <= 1'b0;
					rsp.result <= {quo_q[WORD_BITS-2:0], ~trial[WORD_BITS]};
				end
			end else if (req.start) begin
				rsp.done <= !((req.op == ALU_DIV) && (req.b != '0));
				case (req.op)
					ALU_ADD: rsp.result <= req.a + req.b;
					ALU_SUB: rsp.result <= req.a - req.b;
					ALU_MUL: rsp.result <= prod[WORD_BITS-1:0];
					ALU_EQ:  rsp.result <= word_t'(req.a == req.b);
					ALU_NE:  rsp.result <= word_t'(req.a != req.b);
					ALU_DIV: begin
						if (req.b == '0) begin
							rsp.result <= '1;
						end else begin
							busy_q <= 1'b1;
							cnt_q  <= CNT_BITS'(WORD_BITS);
							quo_q  <= req.a;
							rem_q  <= '0;
							div_q  <= req.b;
						end
					end
					default: rsp.result <= '0;
				endcase
			end else begin
				rsp.done <= 1'b0;
			end
		end
	end
endmodule

// File: design/tiny_16bit_cpu_core.sv
// ----------------------------------------------------------------------------
// tiny_16bit_cpu_core: 16-bit core executing one externally fetched request
// A request is accepted only while idle and in_stall stays high until its
// result has been taken. Load returns, interrupt requests, ignored requests
// and executes that report busy or take an interrupt go from accept straight
// to present; jump, move, load, store, syscall and illegal opcodes pass
// through accept, register read and present; add/sub/mul/compare and divide
// also pass through the shared ALU after the register read, where a nonzero
// divide restores one quotient bit per cycle for all sixteen quotient bits.
// ----------------------------------------------------------------------------
module tiny_16bit_cpu_core import tcpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] instruction,
	input  logic [15:0] load_data,
	input  logic [7:0]  irq_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] program_counter,
	output logic [1:0]  access,
	output logic [15:0] access_address,
	output logic [15:0] store_data,
	output logic [2:0]  event_res,
	output logic [7:0]  event_code
);
	state_t   state_q;
	word_t    rf_q [REG_COUNT];
	word_t    pc_q;
	logic     irq_pend_q;
	logic [7:0] irq_code_q;
	logic     ld_wait_q;
	ridx_t    ld_tgt_q;
	logic [15:0] ins_q;
	ridx_t    dst_q;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic [5:0] ropc;
	logic [1:0] iopc;
	assign ropc = ins_q[14:9];
	assign iopc = ins_q[14:13];

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	tcpu_alu u_alu (.clk(clk), .arst_n(arst_n), .req(alu_req), .rsp(alu_rsp));

	always_comb begin
		alu_req.start = (state_q == ST_READ) && !ins_q[15] && (ropc <= OP_NE);
		alu_req.op    = alu_op_t'(ropc[2:0]);
		alu_req.a     = rf_q[ins_q[5:3]];
		alu_req.b     = rf_q[ins_q[2:0]];
	end

	task automatic put(input logic [1:0] acc, input word_t adr, input word_t dat,
			input logic [2:0] ev, input logic [7:0] cd);
		access         <= acc;
		access_address <= adr;
		store_data     <= dat;
		event_res      <= ev;
		event_code     <= cd;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < REG_COUNT; i++) rf_q[i] <= '0;
			pc_q       <= '0;
			irq_pend_q <= 1'b0;
			irq_code_q <= '0;
			ld_wait_q  <= 1'b0;
			ld_tgt_q   <= '0;
			program_counter <= '0;
			put(ACC_NONE, '0, '0, EV_NONE, '0);
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ins_q <= instruction;
						case (action)
							ACT_EXEC: begin
								if (ld_wait_q) begin
									state_q         <= ST_OUT;
									program_counter <= pc_q;
									put(ACC_NONE, '0, '0, EV_BUSY, '0);
								end else if (irq_pend_q) begin
									state_q         <= ST_OUT;
									program_counter <= pc_q;
									irq_pend_q      <= 1'b0;
									put(ACC_NONE, '0, '0, EV_IRQ, irq_code_q);
								end else begin
									state_q         <= ST_READ;
									pc_q            <= pc_q + 1'b1;
									program_counter <= pc_q + 1'b1;
									put(ACC_NONE, '0, '0, EV_NONE, '0);
								end
							end
							ACT_LOAD: begin
								if (ld_wait_q) begin
									rf_q[ld_tgt_q] <= load_data;
									ld_wait_q      <= 1'b0;
								end
								state_q         <= ST_OUT;
								program_counter <= pc_q;
								put(ACC_NONE, '0, '0, EV_NONE, '0);
							end
							ACT_IRQ: begin
								state_q         <= ST_OUT;
								program_counter <= pc_q;
								if (irq_pend_q) begin
									put(ACC_NONE, '0, '0, EV_REFUSED, irq_code);
								end else begin
									irq_pend_q <= 1'b1;
									irq_code_q <= irq_code;
									put(ACC_NONE, '0, '0, EV_NONE, '0);
								end
							end
							default: begin
								state_q         <= ST_OUT;
								program_counter <= pc_q;
								put(ACC_NONE, '0, '0, EV_NONE, '0);
							end
						endcase
					end
				end
				ST_READ: begin
					dst_q <= ins_q[8:6];
					if (ins_q[15]) begin
						state_q <= ST_OUT;
						case (iopc)
							IOP_JMP: begin
								pc_q <= word_t'(ins_q[8:0]);
								program_counter <= word_t'(ins_q[8:0]);
							end
							IOP_JEQ1: begin
								if (rf_q[ins_q[12:10]] == word_t'(1)) begin
									pc_q <= word_t'(ins_q[8:0]);
									program_counter <= word_t'(ins_q[8:0]);
								end
							end
							IOP_MOVI: rf_q[ins_q[12:10]] <= word_t'(ins_q[8:0]);
							default: put(ACC_NONE, '0, '0, EV_ILLEGAL, 8'(iopc));
						endcase
					end else begin
						case (ropc)
							OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE: state_q <= ST_ALU;
							OP_LOAD: begin
								state_q   <= ST_OUT;
								ld_wait_q <= 1'b1;
								ld_tgt_q  <= ins_q[8:6];
								put(ACC_LOAD, rf_q[ins_q[5:3]], '0, EV_NONE, '0);
							end
							OP_STORE: begin
								state_q <= ST_OUT;
								put(ACC_STORE, rf_q[ins_q[5:3]], rf_q[ins_q[2:0]],
									EV_NONE, '0);
							end
							OP_SYS: begin
								state_q <= ST_OUT;
								put(ACC_NONE, '0, '0, EV_SYSCALL, '0);
							end
							default: begin
								state_q <= ST_OUT;
								put(ACC_NONE, '0, '0, EV_ILLEGAL, 8'(ropc));
							end
						endcase
					end
				end
				ST_ALU: begin
					if (alu_rsp.done) begin
						rf_q[dst_q] <= alu_rsp.result;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
